>>> src/ksts_pkg.sv
package ksts_pkg;

  // Table geometry
  localparam int PLAYERS    = 1024;
  localparam int SCORE_BITS = 24;
  localparam int IDX_W      = $clog2(PLAYERS);
  localparam int CNT_W      = $clog2(PLAYERS + 1);

  // Item field widths
  localparam int KIND_W  = 2;
  localparam int ID_W    = 10;
  localparam int SCORE_W = 16;
  localparam int K_W     = 11;
  localparam int SUM_W   = 32;

  // Word stored per key: present flag over the total
  localparam int KEY_W = SCORE_BITS + 1;

  typedef logic [KIND_W-1:0]     kind_t;
  typedef logic [ID_W-1:0]       id_t;
  typedef logic [SCORE_W-1:0]    score_t;
  typedef logic [K_W-1:0]        k_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [SCORE_BITS-1:0] total_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  // Operation codes
  localparam kind_t KIND_ADD   = 2'd0;
  localparam kind_t KIND_TOP   = 2'd1;
  localparam kind_t KIND_RESET = 2'd2;

  localparam total_t TOTAL_MAX = '1;
  localparam sum_t   SUM_MAX   = '1;

endpackage

>>> src/ksts_if.sv
interface ksts_in_if;
  import ksts_pkg::*;

  logic   valid;
  logic   ready;
  kind_t  kind;
  id_t    player_id;
  score_t score;
  k_t     k;

  modport source (output valid, output kind, output player_id, output score, output k,
                  input ready);
  modport sink   (input valid, input kind, input player_id, input score, input k,
                  output ready);
endinterface

interface ksts_out_if;
  import ksts_pkg::*;

  logic valid;
  logic ready;
  sum_t top_sum;

  modport source (output valid, output top_sum, input ready);
  modport sink   (input valid, input top_sum, output ready);
endinterface

>>> src/keyed_score_table_top_k_sum.sv
// Leaderboard: keeps a 24-bit saturating total per key (1024 keys) and a
// descending sorted list of all entered totals. An add item adds its score to
// a key's total (or enters the key), a reset item zeroes a known key's total,
// and a top item returns the saturating 32-bit sum of the k largest totals.
// One item is handled at a time; ready is high only while the sequencer is
// idle. All work runs through one read/compare/write step on the sorted-list
// RAM, a read state then a check or write state per list entry touched. A top
// item reads min(k, entries) entries. An add or reset of a known key finds the
// old total, closes the gap, then insertion-shifts the new total; a new key
// only insertion-shifts. After reset a clearing pass sweeps all 1024 entries
// of the key table before the first item is accepted.
module keyed_score_table_top_k_sum (
  input  logic        clk,
  input  logic        rst_n,
  ksts_in_if.sink     in_ch,
  ksts_out_if.source  out_ch
);
  import ksts_pkg::*;

  localparam int ADD_W = ((SCORE_BITS > SCORE_W) ? SCORE_BITS : SCORE_W) + 1;
  localparam int CMP_W = ((K_W > CNT_W) ? K_W : CNT_W);

  // Sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_KEY    = 4'd2;
  localparam logic [3:0] S_RF_RD  = 4'd3;
  localparam logic [3:0] S_RF_CHK = 4'd4;
  localparam logic [3:0] S_RS_RD  = 4'd5;
  localparam logic [3:0] S_RS_WR  = 4'd6;
  localparam logic [3:0] S_IN_RD  = 4'd7;
  localparam logic [3:0] S_IN_CHK = 4'd8;
  localparam logic [3:0] S_SM_RD  = 4'd9;
  localparam logic [3:0] S_SM_ACC = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  cnt_t       idx_r, idx_nxt;
  cnt_t       n_r, n_nxt;
  kind_t      kind_r, kind_nxt;
  id_t        id_r, id_nxt;
  score_t     score_r, score_nxt;
  total_t     old_r, old_nxt;
  total_t     val_r, val_nxt;
  sum_t       sum_r, sum_nxt;
  logic       out_valid_r, out_valid_nxt;
  sum_t       top_sum_r, top_sum_nxt;

  // Key table port
  logic             key_we;
  idx_t             key_waddr;
  logic [KEY_W-1:0] key_wdata;
  logic [KEY_W-1:0] key_rdata;

  // Sorted list port
  logic   lst_we;
  idx_t   lst_waddr;
  total_t lst_wdata;
  idx_t   lst_raddr;
  total_t lst_rdata;

  logic              in_acc;
  logic              key_present;
  total_t            key_old;
  logic [ADD_W-1:0]  add_ext;
  total_t            new_total;
  logic [SUM_W:0]    sum_ext;
  cnt_t              idx_inc;
  cnt_t              idx_dec;

  ksts_ram #(.WIDTH(KEY_W), .DEPTH(PLAYERS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (IDX_W'(in_ch.player_id)),
    .rdata (key_rdata)
  );

  ksts_ram #(.WIDTH(SCORE_BITS), .DEPTH(PLAYERS)) u_list_ram (
    .clk   (clk),
    .we    (lst_we),
    .waddr (lst_waddr),
    .wdata (lst_wdata),
    .raddr (lst_raddr),
    .rdata (lst_rdata)
  );

  assign in_ch.ready    = (state_r == S_IDLE);
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.top_sum = top_sum_r;

  assign key_present = key_rdata[KEY_W-1];
  assign key_old     = key_rdata[SCORE_BITS-1:0];
  assign idx_inc     = idx_r + cnt_t'(1);
  assign idx_dec     = idx_r - cnt_t'(1);

  // Saturating new total for add; zero for reset
  always_comb begin
    add_ext = ADD_W'(key_present ? key_old : total_t'(0)) + ADD_W'(score_r);
    if (kind_r == KIND_RESET) begin
      new_total = '0;
    end else if (add_ext > ADD_W'(TOTAL_MAX)) begin
      new_total = TOTAL_MAX;
    end else begin
      new_total = SCORE_BITS'(add_ext);
    end
  end

  // Saturating running sum
  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(lst_rdata);

  // Sorted list read address
  always_comb begin
    unique case (state_r)
      S_RS_RD: lst_raddr = idx_inc[IDX_W-1:0];
      S_IN_RD: lst_raddr = idx_dec[IDX_W-1:0];
      default: lst_raddr = idx_r[IDX_W-1:0];
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    kind_nxt      = kind_r;
    id_nxt        = id_r;
    score_nxt     = score_r;
    old_nxt       = old_r;
    val_nxt       = val_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    top_sum_nxt   = top_sum_r;
    key_we        = 1'b0;
    key_waddr     = idx_r[IDX_W-1:0];
    key_wdata     = '0;
    lst_we        = 1'b0;
    lst_waddr     = idx_r[IDX_W-1:0];
    lst_wdata     = val_r;

    unique case (state_r)
      // Sweep the key table to "not present"
      S_CLEAR: begin
        key_we  = 1'b1;
        idx_nxt = idx_inc;
        if (idx_r == cnt_t'(PLAYERS - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      // Take an item and dispatch
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt  = in_ch.kind;
          id_nxt    = in_ch.player_id;
          score_nxt = in_ch.score;
          idx_nxt   = '0;
          sum_nxt   = '0;
          if (CMP_W'(in_ch.k) < CMP_W'(cnt_r)) begin
            n_nxt = CNT_W'(in_ch.k);
          end else begin
            n_nxt = cnt_r;
          end
          if ((in_ch.kind == KIND_ADD || in_ch.kind == KIND_RESET) &&
              (32'(in_ch.player_id) < 32'(PLAYERS))) begin
            state_nxt = S_KEY;
          end else if (in_ch.kind == KIND_TOP) begin
            state_nxt = S_SM_RD;
          end
        end
      end

      // Update the key entry, then remove and/or insert in the list (a reset of an unknown key does nothing)
      S_KEY: begin
        key_waddr = IDX_W'(id_r);
        if (kind_r == KIND_RESET && !key_present) begin
          state_nxt = S_IDLE;
        end else begin
          key_we    = 1'b1;
          key_wdata = {1'b1, new_total};
          old_nxt   = key_old;
          val_nxt   = new_total;
          if (key_present) begin
            idx_nxt   = '0;
            state_nxt = S_RF_RD;
          end else begin
            idx_nxt   = cnt_r;
            state_nxt = S_IN_RD;
          end
        end
      end

      // Find the old total
      S_RF_RD: begin
        if (idx_r < cnt_r) begin
          state_nxt = S_RF_CHK;
        end else begin
          idx_nxt   = cnt_r;
          state_nxt = S_IN_RD;
        end
      end

      S_RF_CHK: begin
        if (lst_rdata == old_r) begin
          state_nxt = S_RS_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_RF_RD;
        end
      end

      // Close the gap left by the removed total
      S_RS_RD: begin
        if (idx_inc < cnt_r) begin
          state_nxt = S_RS_WR;
        end else begin
          cnt_nxt   = cnt_r - cnt_t'(1);
          idx_nxt   = cnt_r - cnt_t'(1);
          state_nxt = S_IN_RD;
        end
      end

      S_RS_WR: begin
        lst_we    = 1'b1;
        lst_wdata = lst_rdata;
        idx_nxt   = idx_inc;
        state_nxt = S_RS_RD;
      end

      // Insertion shift toward the head
      S_IN_RD: begin
        if (cnt_r >= cnt_t'(PLAYERS)) begin
          state_nxt = S_IDLE;
        end else if (idx_r == '0) begin
          lst_we    = 1'b1;
          cnt_nxt   = cnt_r + cnt_t'(1);
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_IN_CHK;
        end
      end

      S_IN_CHK: begin
        lst_we = 1'b1;
        if (lst_rdata < val_r) begin
          lst_wdata = lst_rdata;
          idx_nxt   = idx_dec;
          state_nxt = S_IN_RD;
        end else begin
          cnt_nxt   = cnt_r + cnt_t'(1);
          state_nxt = S_IDLE;
        end
      end

      // Sum the leading totals
      S_SM_RD: begin
        if (idx_r < n_r) begin
          state_nxt = S_SM_ACC;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SM_ACC: begin
        sum_nxt   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        idx_nxt   = idx_inc;
        state_nxt = S_SM_RD;
      end

      // Hold until the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          top_sum_nxt   = sum_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    kind_r    <= kind_nxt;
    id_r      <= id_nxt;
    score_r   <= score_nxt;
    old_r     <= old_nxt;
    val_r     <= val_nxt;
    sum_r     <= sum_nxt;
    top_sum_r <= top_sum_nxt;
  end

  // Entry count never exceeds the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(PLAYERS))
    else $error("entry count above table depth");

  // Gap-closing writes stay inside the list
  a_shift_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RS_WR) |-> (idx_inc < cnt_r))
    else $error("shift write beyond list end");

  // Summing never changes the entry count
  a_sum_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SM_ACC) |=> $stable(cnt_r))
    else $error("entry count changed during sum");

  // A finished top item reaches the output register
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_ch.ready)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("top result not presented");

endmodule

>>> src/ksts_ram.sv
module ksts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> test/top_k_sum_checker.sv
module top_k_sum_checker (
  input  logic clk,
  input  logic rst_n,
  ksts_in_if   in_ch,
  ksts_out_if  out_ch,
  output int   mismatches,
  output int   sums_pending,
  output int   sums_checked,
  output bit   ceiling_hit
);
  timeunit 1ns;
  timeprecision 1ps;
  import ksts_pkg::*;

  // Per-key totals and the multiset of entered totals, largest first
  total_t key_total [PLAYERS];
  bit     key_known [PLAYERS];
  total_t ranked [$];
  sum_t   sums_due [$];
  sum_t   expected_sum;

  initial begin
    mismatches   = 0;
    sums_pending = 0;
    sums_checked = 0;
    ceiling_hit  = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Drop one occurrence of a total from the ranking
  function automatic void drop_total(input total_t value);
    int i;
    for (i = 0; i < ranked.size(); i++) begin
      if (ranked[i] == value) begin
        ranked.delete(i);
        return;
      end
    end
  endfunction

  // Insert a total behind every entry that is not smaller
  function automatic void place_total(input total_t value);
    int pos;
    pos = 0;
    while (pos < ranked.size() && ranked[pos] >= value)
      pos++;
    ranked.insert(pos, value);
  endfunction

  // Saturating sum of the k largest totals
  function automatic sum_t sum_largest(input k_t k);
    longint unsigned acc;
    int              n;
    int              i;
    acc = 0;
    n   = (int'(k) < ranked.size()) ? int'(k) : ranked.size();
    for (i = 0; i < n; i++) begin
      acc += ranked[i];
      if (acc > SUM_MAX)
        acc = SUM_MAX;
    end
    return sum_t'(acc);
  endfunction

  // Advance the table by one accepted item; queue the sum a top item owes
  task automatic apply_item(input kind_t kind, input id_t id, input score_t score,
                            input k_t k);
    logic [SCORE_BITS:0] grown;
    case (kind)
      KIND_ADD: begin
        if (key_known[id]) begin
          drop_total(key_total[id]);
          grown = (SCORE_BITS + 1)'(key_total[id]) + (SCORE_BITS + 1)'(score);
        end else begin
          grown = (SCORE_BITS + 1)'(score);
          key_known[id] = 1'b1;
        end
        if (grown > (SCORE_BITS + 1)'(TOTAL_MAX)) begin
          grown       = (SCORE_BITS + 1)'(TOTAL_MAX);
          ceiling_hit = 1'b1;
        end
        key_total[id] = grown[SCORE_BITS-1:0];
        place_total(key_total[id]);
      end
      KIND_TOP: begin
        sums_due.push_back(sum_largest(k));
      end
      KIND_RESET: begin
        if (key_known[id]) begin
          drop_total(key_total[id]);
          key_total[id] = '0;
          place_total('0);
        end
      end
      default: begin
      end
    endcase
  endtask

  // Compare each delivered sum with the oldest one owed, then take in the new item
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (sums_due.size() == 0) begin
          report_mismatch($sformatf("top_sum %0d delivered with none owed", out_ch.top_sum));
        end else begin
          expected_sum = sums_due.pop_front();
          if (out_ch.top_sum !== expected_sum)
            report_mismatch($sformatf("top_sum %0d, predicted %0d",
                                      out_ch.top_sum, expected_sum));
          sums_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready)
        apply_item(in_ch.kind, in_ch.player_id, in_ch.score, in_ch.k);
      sums_pending = sums_due.size();
    end
  end

endmodule

>>> test/tb_keyed_score_table_top_k_sum.sv
module tb_keyed_score_table_top_k_sum;
  timeunit 1ns;
  timeprecision 1ps;
  import ksts_pkg::*;

  localparam int    CLK_HALF     = 5;
  localparam int    LIMIT_CYCLES = 1_000_000;
  localparam int    HOLD_CYCLES  = 300;
  localparam int    TAIL_CYCLES  = 1000;
  localparam int    BURST_ITEMS  = 300;
  localparam int    SEGMENT_ITEMS = 33;
  localparam int    POOL_KEYS    = 32;
  localparam id_t   HOT_KEY      = 10'd7;
  localparam kind_t KIND_UNUSED  = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ksts_in_if  in_ch ();
  ksts_out_if out_ch ();

  int mismatches;
  int sums_pending;
  int sums_checked;
  bit ceiling_hit;

  int gap_pct       = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int adds_sent     = 0;
  int tops_sent     = 0;
  int resets_sent   = 0;
  int unused_sent   = 0;

  keyed_score_table_top_k_sum i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  top_k_sum_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches   (mismatches),
    .sums_pending (sums_pending),
    .sums_checked (sums_checked),
    .ceiling_hit  (ceiling_hit)
  );

  always #CLK_HALF clk = ~clk;

  // Stop a hung run
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("tb: failure");
    $finish;
  end

  // Take results; stall at random, or hold off for a long stretch on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input kind_t kind, input id_t id, input score_t score,
                           input k_t k);
    if ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.player_id <= id;
    in_ch.score     <= score;
    in_ch.k         <= k;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    case (kind)
      KIND_ADD:   adds_sent++;
      KIND_TOP:   tops_sent++;
      KIND_RESET: resets_sent++;
      default:    unused_sent++;
    endcase
  endtask

  // Lower valid and wait until every owed sum has come back
  task automatic drain_sums();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sums_pending != 0);
  endtask

  // Mostly a small pool of keys so the sorted list stays short
  function automatic id_t pick_key();
    if ($urandom_range(11) == 0)
      return id_t'($urandom_range(PLAYERS - 1));
    return id_t'($urandom_range(POOL_KEYS - 1));
  endfunction

  function automatic score_t pick_score();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return score_t'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic k_t pick_k();
    case ($urandom_range(3))
      0:       return k_t'($urandom_range((1 << K_W) - 1));
      1:       return k_t'($urandom_range(1));
      default: return k_t'($urandom_range(48));
    endcase
  endfunction

  // One random item; unused kinds do not count toward the segment
  task automatic send_random_item(output bit counted);
    int pick;
    pick    = $urandom_range(99);
    counted = 1'b1;
    if (pick < 55) begin
      send_item(KIND_ADD, pick_key(), pick_score(), k_t'($urandom));
    end else if (pick < 80) begin
      send_item(KIND_TOP, id_t'($urandom), score_t'($urandom), pick_k());
    end else if (pick < 95) begin
      send_item(KIND_RESET, pick_key(), score_t'($urandom), k_t'($urandom));
    end else begin
      send_item(KIND_UNUSED, id_t'($urandom), score_t'($urandom), k_t'($urandom));
      counted = 1'b0;
    end
  endtask

  initial begin
    int phase;
    int sent;
    int i;
    bit counted;

    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_ADD;
    in_ch.player_id <= '0;
    in_ch.score     <= '0;
    in_ch.k         <= '0;
    rst_n           <= 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, unknown reset, zero score entry, field extremes,
    // zero and oversized k, unused kind, resets of known keys, equal totals.
    // Sum saturation needs 257 keys at the total ceiling and lies beyond this run.
    send_item(KIND_TOP,    10'd0,     16'd0,      11'd5);
    send_item(KIND_RESET,  10'd3,     16'd0,      11'd0);
    send_item(KIND_ADD,    10'd0,     16'd0,      11'd0);
    send_item(KIND_ADD,    10'd1023,  16'hFFFF,   11'd0);
    send_item(KIND_ADD,    10'h155,   16'h5555,   11'd0);
    send_item(KIND_ADD,    10'h2AA,   16'hAAAA,   11'd0);
    send_item(KIND_ADD,    10'd1023,  16'd1,      11'd0);
    send_item(KIND_TOP,    10'd0,     16'd0,      11'd0);
    send_item(KIND_TOP,    10'd0,     16'd0,      11'd1);
    send_item(KIND_TOP,    10'd0,     16'd0,      11'd2);
    send_item(KIND_TOP,    10'd1023,  16'hFFFF,   11'd2047);
    send_item(KIND_TOP,    10'd0,     16'd0,      11'd1024);
    send_item(KIND_UNUSED, 10'd5,     16'hFFFF,   11'd2047);
    send_item(KIND_RESET,  10'd1023,  16'd0,      11'd0);
    send_item(KIND_TOP,    10'd0,     16'd0,      11'd3);
    send_item(KIND_RESET,  10'd0,     16'd0,      11'd0);
    send_item(KIND_ADD,    10'd1023,  16'd5,      11'd0);
    send_item(KIND_ADD,    10'h155,   16'h5555,   11'd0);
    send_item(KIND_TOP,    10'd0,     16'd0,      11'd2);
    send_item(KIND_RESET,  10'h2AA,   16'd0,      11'd0);
    send_item(KIND_TOP,    10'd0,     16'd0,      11'd2047);
    drain_sums();

    // Pile large scores onto one key until its total clips, polling sums on the way
    for (i = 0; i < BURST_ITEMS; i++) begin
      gap_pct   = (i < BURST_ITEMS / 2) ? 0 : 77;
      stall_pct = (i < BURST_ITEMS / 2) ? 77 : 0;
      if (i % 10 == 9)
        send_item(KIND_TOP, id_t'($urandom), score_t'($urandom), k_t'($urandom_range(3)));
      else
        send_item(KIND_ADD, HOT_KEY, score_t'($urandom_range(16'hF800, 16'hFFFF)),
                  k_t'($urandom));
    end
    drain_sums();

    // Hold results back while items keep coming, so the block backs up
    gap_pct   = 0;
    stall_pct = 0;
    hold_requests++;
    send_item(KIND_TOP,   10'd0,   16'd0,    11'd4);
    send_item(KIND_ADD,   10'd9,   16'd1234, 11'd0);
    send_item(KIND_TOP,   10'd0,   16'd0,    11'd2047);
    send_item(KIND_ADD,   HOT_KEY, 16'hFFFF, 11'd0);
    send_item(KIND_RESET, 10'd9,   16'd0,    11'd0);
    send_item(KIND_TOP,   10'd0,   16'd0,    11'd3);
    drain_sums();

    // Random items across the idling phases, twice round
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 77; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 77; end
        default: begin gap_pct = 9;  stall_pct = 9;  end
      endcase
      sent = 0;
      while (sent < SEGMENT_ITEMS) begin
        send_random_item(counted);
        if (counted)
          sent++;
      end
      if (phase == 3)
        drain_sums();
    end

    // Let the last sums and any stray result arrive
    drain_sums();
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run: %0d add, %0d top-k, %0d reset and %0d unused-kind items; %0d sums checked",
             adds_sent, tops_sent, resets_sent, unused_sent, sums_checked);
    $display("run: key total ceiling %0s; long result hold-off and full drains exercised",
             ceiling_hit ? "reached" : "not reached");
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
